FILE: rtl/iot_pkg.sv
package iot_pkg;

	// default number of stored offsets (instructions 1 to capacity)
	localparam int TABLE_ENTRIES_DEF = 256;

	// field widths
	localparam int ADDR_W   = 64;
	localparam int OFF_W    = 16;
	localparam int COUNT_W  = 9;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_IDX_Q = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADR_Q = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	// shared adder operations
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sum;
		logic              borrow;
	} alu_res_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0]  instr_index;
		logic [OFF_W-1:0]  offset_value;
		logic [ADDR_W-1:0] query_addr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    instr_offset;
		logic [ADDR_W-1:0]   instr_addr;
		logic [OFF_W-1:0]    instr_size;
	} res_t;

endpackage

FILE: rtl/iot_ram.sv
module iot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/iot_alu.sv
module iot_alu
	import iot_pkg::*;
(
	input  alu_op_t           op,
	input  logic [ADDR_W-1:0] a,
	input  logic [ADDR_W-1:0] b,
	output alu_res_t          res
);

	logic [ADDR_W:0]   full;
	logic [ADDR_W-1:0] b_in;

	// one 64-bit adder; subtract as a plus inverted b plus one
	always_comb begin
		b_in       = (op == ALU_SUB) ? ~b : b;
		full       = {1'b0, a} + {1'b0, b_in} + {{ADDR_W{1'b0}}, (op == ALU_SUB)};
		res.sum    = full[ADDR_W-1:0];
		res.borrow = (op == ALU_SUB) && !full[ADDR_W];
	end

endmodule

FILE: rtl/instruction_offset_table_core.sv
// channel   | signals                                | handshake
// ----------+----------------------------------------+------------------------------
// request   | start, busy, req                       | taken when start and !busy
// result    | done, res                              | one cycle, strobed by done
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid and ready
//
// An address query reads n offsets (at most instr_count) in its walk; the walk
// reads one table entry a cycle through the store's single read port.
// After reset the store is cleared one entry a cycle while busy stays high;
// configuration writes are taken throughout.
// The receiver cannot stall; a new request may be taken in the strobe cycle.
module instruction_offset_table_core
	import iot_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	localparam int TAB_AW = $clog2(TABLE_ENTRIES);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_WRITE   = 10'b0000000100,
		S_IQ_CHK  = 10'b0000001000,
		S_IQ_CUR  = 10'b0000010000,
		S_IQ_NXT  = 10'b0000100000,
		S_AQ_SUB  = 10'b0001000000,
		S_AQ_RNG  = 10'b0010000000,
		S_AQ_WALK = 10'b0100000000,
		S_FIN     = 10'b1000000000
	} state_t;

	state_t                state_q;
	logic [TAB_AW-1:0]     clr_q;
	logic [ADDR_W-1:0]     base_q;
	logic [OFF_W-1:0]      bsize_q;
	logic [COUNT_W-1:0]    count_q;
	req_t                  req_q;
	logic [STATUS_W-1:0]   st_q;
	logic [OFF_W-1:0]      cur_q;
	logic [OFF_W-1:0]      size_q;
	logic                  has_next_q;
	logic [ADDR_W-1:0]     diff_q;
	logic [COUNT_W-1:0]    i_q;
	logic                  rd_ok_q;
	logic                  done_q;
	res_t                  res_q;

	logic [OFF_W-1:0]      rd_idx;
	logic                  rd_ok;
	logic [OFF_W-1:0]      rd_data;
	logic [OFF_W-1:0]      rd_val;
	logic                  wr_en;
	logic [TAB_AW-1:0]     wr_addr;
	logic [OFF_W-1:0]      wr_data;
	logic                  wr_ok;
	logic                  wr_live;
	logic [OFF_W:0]        idx_inc;
	logic [COUNT_W-1:0]    i_inc;
	alu_op_t               alu_op;
	logic [ADDR_W-1:0]     alu_a;
	logic [ADDR_W-1:0]     alu_b;
	alu_res_t              alu_r;

	// true when index i lives in the store (1 to capacity)
	function automatic logic in_tab(input logic [OFF_W-1:0] i);
		in_tab = (i != '0) && ({1'b0, i} <= (OFF_W+1)'(TABLE_ENTRIES));
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	assign idx_inc = {1'b0, req_q.instr_index} + (OFF_W+1)'(1);
	assign i_inc   = i_q + COUNT_W'(1);

	// table read index for each step
	always_comb begin
		case (state_q)
			S_IQ_CHK:  rd_idx = req_q.instr_index;
			S_IQ_CUR:  rd_idx = idx_inc[OFF_W-1:0];
			S_AQ_WALK: rd_idx = {{(OFF_W-COUNT_W){1'b0}}, i_inc};
			default:   rd_idx = '0;
		endcase
	end

	assign rd_ok  = in_tab(rd_idx);
	assign rd_val = rd_ok_q ? rd_data : '0;

	// write port: clearing pass or a stored offset
	assign wr_live = (req_q.instr_index != '0) && (req_q.offset_value != '0);
	assign wr_ok   = in_tab(req_q.instr_index);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_WRITE) begin
			wr_en   = wr_live && wr_ok;
			wr_addr = TAB_AW'(req_q.instr_index - OFF_W'(1));
			wr_data = req_q.offset_value;
		end
	end

	iot_ram #(
		.WIDTH (OFF_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (TAB_AW'(rd_idx - OFF_W'(1))),
		.rdata (rd_data)
	);

	// operands of the shared adder
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_IQ_CHK: begin
				alu_a = {{(ADDR_W-OFF_W){1'b0}}, req_q.instr_index};
				alu_b = {{(ADDR_W-COUNT_W){1'b0}}, count_q};
			end
			S_IQ_CUR: begin
				alu_a = {{(ADDR_W-OFF_W-1){1'b0}}, idx_inc};
				alu_b = {{(ADDR_W-COUNT_W){1'b0}}, count_q};
			end
			S_IQ_NXT: begin
				alu_a = {{(ADDR_W-OFF_W){1'b0}}, (has_next_q ? rd_val : bsize_q)};
				alu_b = {{(ADDR_W-OFF_W){1'b0}}, cur_q};
			end
			S_AQ_SUB: begin
				alu_a = req_q.query_addr;
				alu_b = base_q;
			end
			S_AQ_RNG: begin
				alu_a = diff_q;
				alu_b = {{(ADDR_W-OFF_W){1'b0}}, bsize_q};
			end
			S_AQ_WALK: begin
				alu_a = {{(ADDR_W-OFF_W){1'b0}}, diff_q[OFF_W-1:0]};
				alu_b = {{(ADDR_W-OFF_W){1'b0}}, rd_val};
			end
			S_FIN: begin
				alu_op = ALU_ADD;
				alu_a  = base_q;
				alu_b  = {{(ADDR_W-OFF_W){1'b0}}, cur_q};
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	iot_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_r)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bsize_q <= '0;
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_SIZE:  bsize_q <= cfg_data[OFF_W-1:0];
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default:   ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TAB_AW'(1);
					if (clr_q == TAB_AW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						case (req.kind)
							KIND_WRITE: state_q <= S_WRITE;
							KIND_IDX_Q: state_q <= S_IQ_CHK;
							KIND_ADR_Q: state_q <= S_AQ_SUB;
							default:    state_q <= S_FIN;
						endcase
					end
				end
				S_WRITE:  state_q <= S_FIN;
				S_IQ_CHK: state_q <= alu_r.borrow ? S_IQ_CUR : S_FIN;
				S_IQ_CUR: state_q <= S_IQ_NXT;
				S_IQ_NXT: state_q <= S_FIN;
				S_AQ_SUB: state_q <= alu_r.borrow ? S_FIN : S_AQ_RNG;
				S_AQ_RNG: begin
					if (!alu_r.borrow || count_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_AQ_WALK;
					end
				end
				S_AQ_WALK: begin
					if (alu_r.borrow || i_inc == count_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		rd_ok_q <= rd_ok;
		case (state_q)
			S_IDLE: begin
				req_q  <= req;
				cur_q  <= '0;
				size_q <= '0;
				i_q    <= '0;
				st_q   <= (req.kind == KIND_WRITE || req.kind == KIND_IDX_Q ||
					req.kind == KIND_ADR_Q) ? ST_OK : ST_INVALID;
			end
			S_WRITE: begin
				if (wr_live && !wr_ok) begin
					st_q <= ST_REJECT;
				end
			end
			S_IQ_CHK: begin
				if (!alu_r.borrow) begin
					st_q <= ST_INVALID;
				end
			end
			S_IQ_CUR: begin
				cur_q      <= rd_val;
				has_next_q <= alu_r.borrow;
			end
			S_IQ_NXT: begin
				size_q <= alu_r.sum[OFF_W-1:0];
			end
			S_AQ_SUB: begin
				diff_q <= alu_r.sum;
				if (alu_r.borrow) begin
					st_q <= ST_INVALID;
				end
			end
			S_AQ_RNG: begin
				if (!alu_r.borrow) begin
					st_q <= ST_INVALID;
				end
			end
			S_AQ_WALK: begin
				// stop at the first offset above the distance, keeping the last one
				if (!alu_r.borrow) begin
					cur_q <= rd_val;
					i_q   <= i_inc;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			res_q.status <= st_q;
			if (st_q == ST_OK && req_q.kind != KIND_WRITE) begin
				res_q.instr_offset <= cur_q;
				res_q.instr_addr   <= alu_r.sum;
				res_q.instr_size   <= size_q;
			end else begin
				res_q.instr_offset <= '0;
				res_q.instr_addr   <= '0;
				res_q.instr_size   <= '0;
			end
		end
	end

endmodule

FILE: rtl/iot_chk.sv
module iot_chk
	import iot_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	// a taken request keeps the block busy in the next cycle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// a result is strobed only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// no two results are strobed in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	// failed and rejected requests carry zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status != ST_OK) |->
		(res.instr_offset == '0 && res.instr_addr == '0 && res.instr_size == '0))
		else $error("error result with non-zero fields");

endmodule

bind instruction_offset_table_core iot_chk u_iot_chk (.*);
